/* src/tagged_packet_visualizer_parser_macros.svh */
// Assertion macros for the tagged packet parser.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef TAGGED_PACKET_VISUALIZER_PARSER_MACROS_SVH
`define TAGGED_PACKET_VISUALIZER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TPVP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpvp check failed");

// next-cycle implication
`define TPVP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpvp check failed");

`else

`define TPVP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TPVP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/tpvp_pkg.sv */
// Shared types, constants and arithmetic helpers for the tagged packet parser.
// No dependencies; imported by tpvp_bin_ram and the top level.
package tpvp_pkg;

    localparam int BIN_COUNT   = 32;
    localparam int TAG_LEN     = 4;
    localparam int WAVE_LEN    = 256;
    localparam int SCREEN_ROWS = 64;

    localparam int BIN_AW    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int ROW_MAX   = SCREEN_ROWS - 1;
    localparam int LVL_W     = $clog2(SCREEN_ROWS);
    localparam int TAG_CNT_W = $clog2(TAG_LEN);
    localparam int PCNT_W    = 9;

    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_BAR  = "BAR ";
    localparam logic [31:0] TAG_POT  = "POT ";
    localparam logic [31:0] TAG_MODE = "MODE";
    localparam logic [31:0] TAG_FFT  = "FFT ";

    // display modes
    localparam logic [7:0] MODE_BAR  = 8'd0;
    localparam logic [7:0] MODE_WAVE = 8'd1;
    localparam logic [7:0] MODE_SPEC = 8'd2;
    localparam logic [7:0] MODE_RST  = MODE_WAVE;

    typedef enum logic {
        PH_TAG,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        PT_WAVE,
        PT_BAR,
        PT_POT,
        PT_MODE,
        PT_FFT
    } t_ptype;

    typedef enum logic [1:0] {
        EV_WAVE,
        EV_BAR,
        EV_BIN,
        EV_MODE
    } t_event;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        logic [1:0] event_res;
        logic [6:0] position;
        logic [6:0] level;
        logic       is_trough;
        logic       packet_end;
        logic [7:0] mode_now;
    } t_out_res;

    typedef struct packed {
        logic   hit;
        t_ptype ptype;
    } t_tag_hit;

    // one item in flight between parser and output
    typedef struct packed {
        logic       emit;
        logic       wr;
        t_event     ev;
        logic [6:0] pos;
        logic [7:0] val;
        logic       trough;
        logic       pend;
        logic [7:0] mode;
    } t_work;

    typedef struct packed {
        logic              en;
        logic [BIN_AW-1:0] addr;
    } t_bin_rd;

    typedef struct packed {
        logic              en;
        logic [BIN_AW-1:0] addr;
        logic [7:0]        data;
    } t_bin_wr;

    function automatic t_tag_hit f_tag_lookup(input logic [31:0] tag);
        t_tag_hit h;
        h.hit   = 1'b1;
        h.ptype = PT_WAVE;
        if (tag == TAG_WAVE) begin
            h.ptype = PT_WAVE;
        end else if (tag == TAG_BAR) begin
            h.ptype = PT_BAR;
        end else if (tag == TAG_POT) begin
            h.ptype = PT_POT;
        end else if (tag == TAG_MODE) begin
            h.ptype = PT_MODE;
        end else if (tag == TAG_FFT) begin
            h.ptype = PT_FFT;
        end else begin
            h.hit = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [PCNT_W-1:0] f_pkt_len(input t_ptype pt);
        logic [PCNT_W-1:0] len;
        case (pt)
            PT_WAVE: len = PCNT_W'(WAVE_LEN);
            PT_FFT:  len = PCNT_W'(BIN_COUNT);
            default: len = PCNT_W'(1);
        endcase
        return len;
    endfunction

    // floor(x / 255): shift estimate, low by at most one, then one correction
    function automatic logic [8:0] f_div255(input logic [15:0] x);
        logic [8:0]  q;
        logic [16:0] r;
        q = 9'((17'(x) + 17'(x >> 8)) >> 8);
        r = 17'(x) - ((17'(q) << 8) - 17'(q));
        if (r >= 17'd255) begin
            q = q + 9'd1;
        end
        return q;
    endfunction

    // floor(s / 11) for s <= 2805: 186/2048 reciprocal, then one correction
    function automatic logic [7:0] f_div11(input logic [11:0] s);
        logic [19:0] p;
        logic [7:0]  q;
        logic [11:0] r;
        p = 20'(s) * 20'd186;
        q = 8'(p >> 11);
        r = s - 12'(q) * 12'd11;
        if (r >= 12'd11) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

    // instant rise, else (old*6 + new*5) / 11
    function automatic logic [7:0] f_smooth(input logic [7:0] old_v, input logic [7:0] new_v);
        logic [11:0] s;
        s = 12'(old_v) * 12'd6 + 12'(new_v) * 12'd5;
        return (new_v > old_v) ? new_v : f_div11(s);
    endfunction

    // (mode + 1) mod 3 from base-4 digit residues
    function automatic logic [7:0] f_mode_next(input logic [7:0] mode);
        logic [9:0] x;
        logic [1:0] d;
        logic [2:0] acc;
        logic [1:0] res;
        x   = 10'(mode) + 10'd1;
        res = 2'd0;
        for (int i = 0; i < 5; i++) begin
            d   = x[2*i +: 2];
            acc = 3'(res) + ((d == 2'd3) ? 3'd0 : 3'(d));
            res = (acc >= 3'd3) ? 2'(acc - 3'd3) : 2'(acc);
        end
        return 8'(res);
    endfunction

endpackage

/* src/tpvp_bin_ram.sv */
// Spectrum bin store: synchronous-read RAM with per-entry valid bits.
// Same-address write/read forwarding. Depends on tpvp_pkg.
module tpvp_bin_ram
    import tpvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bin_rd    i_rd,
    input  t_bin_wr    i_wr,
    output logic [7:0] o_rd_data
);

    logic [7:0]           r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_vld;
    logic [7:0]           r_rd_data;
    logic [7:0]           r_fwd_data;
    logic                 r_rd_vld;
    logic                 r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data  <= r_mem[i_rd.addr];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
                r_fwd    <= i_wr.en && (i_wr.addr == i_rd.addr);
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : 8'd0);

endmodule

/* src/tagged_packet_visualizer_parser.sv */
// Tagged packet parser for an audio visualizer.
// Depends on tpvp_pkg, tpvp_bin_ram and the assertion macro header.
//
// Input channel (i_in_valid / o_in_stall, i_in_req): one request per accepted
// cycle, either a received serial byte or a debounced mode button press.
// Bytes form packets: 4-byte ASCII tag, then a fixed-length payload handled
// byte by byte. Output channel (o_out_valid / i_out_stall, o_out_res): zero or
// one result per request, in request order.
// Throughput: one request per cycle while o_in_stall is low. Each result
// passes stage B (bin read-modify-write), stage C (level scale), then r_o.
// Spectrum bins live in a synchronous RAM; the bin update is read at accept
// and written back as the item leaves stage B, with write-to-read forwarding.
// Reset: parser returns to tag search, display mode 1, bar level 0; bins read
// as zero through per-entry valid bits, so no clearing pass is needed and the
// block takes requests on the first cycle after reset.
// Receiver stall: results wait in the output register; empty pipeline slots
// are squeezed out, and o_in_stall rises only when all three stages are full
// and the receiver stalls.
`include "tagged_packet_visualizer_parser_macros.svh"

module tagged_packet_visualizer_parser
    import tpvp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    // parser state
    t_phase                r_phase, n_phase;
    logic [7:0]            r_tag [TAG_LEN-1];
    logic [7:0]            n_tag [TAG_LEN-1];
    logic [TAG_CNT_W-1:0]  r_tag_cnt, n_tag_cnt;
    t_ptype                r_ptype, n_ptype;
    logic [PCNT_W-1:0]     r_pcnt, n_pcnt;
    logic [7:0]            r_mode, n_mode;
    logic [LVL_W-1:0]      r_bar;

    // pipeline
    logic     r_b_vld, r_c_vld, r_o_vld;
    t_work    r_b, r_c, n_work;
    t_work    c_work;
    t_out_res r_o;

    logic     en_b, en_c, en_o;
    logic     accept, is_byte, tag_full, pkt_last;
    t_tag_hit hit;
    logic [8:0] wave_q, bar_q, bin_q;
    logic [7:0] bin_rd, bin_new, c_val;
    logic [LVL_W-1:0] bar_new;
    t_bin_rd  bin_rd_req;
    t_bin_wr  bin_wr_req;

    assign en_o = !r_o_vld || !i_out_stall;
    assign en_c = !r_c_vld || en_o;
    assign en_b = !r_b_vld || en_c;

    assign o_in_stall = !en_b;
    assign accept     = i_in_valid && en_b;
    assign is_byte    = accept && !i_in_req.kind;

    assign tag_full = (r_tag_cnt == TAG_CNT_W'(TAG_LEN - 1));
    assign hit      = f_tag_lookup({r_tag[0], r_tag[1], r_tag[2], i_in_req.rx_byte});
    assign pkt_last = ((10'(r_pcnt) + 10'd1) >= 10'(f_pkt_len(r_ptype)));

    assign wave_q = f_div255(16'(i_in_req.rx_byte) * 16'(ROW_MAX));
    assign bar_q  = wave_q;

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (is_byte) begin
            case (r_phase)
                PH_TAG: begin
                    if (tag_full && hit.hit) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (pkt_last) begin
                        n_phase = PH_TAG;
                    end
                end
                default: n_phase = PH_TAG;
            endcase
        end
    end

    // parser datapath and work item
    always_comb begin
        n_tag     = r_tag;
        n_tag_cnt = r_tag_cnt;
        n_ptype   = r_ptype;
        n_pcnt    = r_pcnt;
        n_mode    = r_mode;
        n_work    = '0;

        if (accept && i_in_req.kind) begin
            n_mode      = f_mode_next(r_mode);
            n_work.emit = 1'b1;
            n_work.ev   = EV_MODE;
        end else if (is_byte) begin
            case (r_phase)
                PH_TAG: begin
                    if (tag_full) begin
                        n_tag_cnt = '0;
                        if (hit.hit) begin
                            n_ptype = hit.ptype;
                            n_pcnt  = '0;
                        end
                    end else begin
                        n_tag[r_tag_cnt] = i_in_req.rx_byte;
                        n_tag_cnt        = r_tag_cnt + TAG_CNT_W'(1);
                    end
                end
                PH_PAYLOAD: begin
                    n_work.pend = pkt_last;
                    case (r_ptype)
                        PT_WAVE: begin
                            if (r_mode == MODE_WAVE) begin
                                n_work.emit   = 1'b1;
                                n_work.ev     = EV_WAVE;
                                n_work.pos    = 7'(r_pcnt >> 1);
                                n_work.val    = 8'(9'(ROW_MAX) - wave_q);
                                n_work.trough = r_pcnt[0];
                            end
                        end
                        PT_BAR: begin
                            if (r_mode == MODE_BAR) begin
                                n_work.emit = 1'b1;
                                n_work.ev   = EV_BAR;
                                n_work.val  = 8'(bar_q);
                            end
                        end
                        PT_MODE: n_mode = i_in_req.rx_byte;
                        PT_FFT: begin
                            if (r_pcnt < PCNT_W'(BIN_COUNT)) begin
                                n_work.wr   = 1'b1;
                                n_work.emit = (r_mode == MODE_SPEC);
                                n_work.ev   = EV_BIN;
                                n_work.pos  = 7'(r_pcnt);
                                n_work.val  = i_in_req.rx_byte;
                            end
                        end
                        default: ;
                    endcase
                    if (pkt_last) begin
                        n_tag_cnt = '0;
                        n_pcnt    = '0;
                    end else begin
                        n_pcnt = r_pcnt + PCNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
        n_work.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_tag_cnt <= '0;
            r_ptype   <= PT_WAVE;
            r_pcnt    <= '0;
            r_mode    <= MODE_RST;
            for (int i = 0; i < TAG_LEN - 1; i++) begin
                r_tag[i] <= 8'd0;
            end
        end else begin
            r_phase   <= n_phase;
            r_tag     <= n_tag;
            r_tag_cnt <= n_tag_cnt;
            r_ptype   <= n_ptype;
            r_pcnt    <= n_pcnt;
            r_mode    <= n_mode;
        end
    end

    // bin RAM: read at accept, write back as the item leaves stage B
    assign bin_rd_req.en   = accept && n_work.wr;
    assign bin_rd_req.addr = n_work.pos[BIN_AW-1:0];
    assign bin_wr_req.en   = r_b_vld && en_c && r_b.wr;
    assign bin_wr_req.addr = r_b.pos[BIN_AW-1:0];
    assign bin_wr_req.data = bin_new;

    tpvp_bin_ram u_bins (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (bin_rd_req),
        .i_wr      (bin_wr_req),
        .o_rd_data (bin_rd)
    );

    assign bin_new = f_smooth(bin_rd, r_b.val);
    assign bar_new = LVL_W'(f_smooth(8'(r_bar), r_b.val));

    always_comb begin
        case (r_b.ev)
            EV_BIN:  c_val = bin_new;
            EV_BAR:  c_val = 8'(bar_new);
            default: c_val = r_b.val;
        endcase
    end

    always_comb begin
        c_work     = r_b;
        c_work.val = c_val;
    end

    assign bin_q = f_div255(16'(r_c.val) * 16'(SCREEN_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_bar   <= '0;
        end else begin
            if (en_b) begin
                r_b_vld <= accept && (n_work.emit || n_work.wr);
            end
            if (en_c) begin
                r_c_vld <= r_b_vld && r_b.emit;
            end
            if (en_o) begin
                r_o_vld <= r_c_vld;
            end
            if (r_b_vld && en_c && r_b.emit && (r_b.ev == EV_BAR)) begin
                r_bar <= bar_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && en_b) begin
            r_b <= n_work;
        end
        if (r_b_vld && en_c) begin
            r_c <= c_work;
        end
        if (r_c_vld && en_o) begin
            r_o.event_res  <= r_c.ev;
            r_o.position   <= r_c.pos;
            r_o.level      <= (r_c.ev == EV_BIN) ? 7'(bin_q) : 7'(r_c.val);
            r_o.is_trough  <= r_c.trough;
            r_o.packet_end <= r_c.pend;
            r_o.mode_now   <= r_c.mode;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_res   = r_o;

    `TPVP_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_b_vld && r_c_vld && r_o_vld)
    `TPVP_ASSERT_NXT(a_button_mode, i_clk, i_rst_n, accept && i_in_req.kind, r_b_vld && r_b.ev == EV_MODE && r_b.mode < 8'd3)
    `TPVP_ASSERT_IMP(a_tag_count_idle, i_clk, i_rst_n, r_phase == PH_TAG, r_pcnt == '0)

endmodule
